>>> rtl/signed_area_row_coverage_scan_defines.svh
// assertion macros for the signed-area row coverage scan checker
`ifndef SIGNED_AREA_ROW_COVERAGE_SCAN_DEFINES_SVH
`define SIGNED_AREA_ROW_COVERAGE_SCAN_DEFINES_SVH

// clocked assertion, masked while reset is high
`define SARCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SARCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sarcs_pkg.sv
// shared types, constants and the coverage function of the row coverage scan
package sarcs_pkg;

  localparam int MAX_ROW_WIDTH_DEF = 256;
  localparam int MIN_GAP_DEF       = 8;

  localparam int DELTA_W = 16;
  localparam int WSUM_W  = 24;
  localparam int ROW_W   = 10;
  localparam int XORG_W  = 10;
  localparam int COV_W   = 8;
  localparam int SPANX_W = 11;
  localparam int SLEN_W  = 9;
  localparam int GAP_W   = 4;

  // Q11 fixed point: 1.0 is 2048, even-odd period is 2.0
  localparam int Q11_ONE  = 2048;
  localparam int PERIOD_W = 12;
  localparam int MAG_W    = PERIOD_W + 1;
  localparam int ROUND_W  = 9;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILL_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_X_ORIGIN  = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               coverage_valid;
    logic [COV_W-1:0]   coverage_byte;
    logic               span_valid;
    logic [SPANX_W-1:0] span_x;
    logic [ROW_W-1:0]   span_y;
    logic [SLEN_W-1:0]  span_length;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic    two;
    result_t first;
    result_t second;
  } push_t;

  // winding sum to coverage byte, clamp or triangle fold, round, fold 256 to 255
  function automatic logic [COV_W-1:0] cover_byte(logic [WSUM_W-1:0] w, logic odd_rule);
    logic [WSUM_W-1:0]  mag;
    logic [MAG_W-1:0]   c;
    logic [ROUND_W-1:0] a;
    mag = w[WSUM_W-1] ? (~w + 1'b1) : w;
    if (mag > WSUM_W'(Q11_ONE)) begin
      if (!odd_rule) begin
        c = MAG_W'(Q11_ONE);
      end else begin
        c = {1'b0, mag[PERIOD_W-1:0]};
        if (c > MAG_W'(Q11_ONE)) begin
          c = MAG_W'(2 * Q11_ONE) - c;
        end
      end
    end else begin
      c = mag[MAG_W-1:0];
    end
    a = ROUND_W'((c + MAG_W'(4)) >> 3);
    return COV_W'(a - (a >> 8));
  endfunction

endpackage

>>> rtl/signed_area_row_coverage_scan.sv
// signed-area row coverage scan: per-column coverage bytes and closed spans
//
// cell channel: one accumulator column per transfer (cell_valid / cell_stall),
// columns of a row in order, last_in_row on the final one.
// result channel: result_valid / result_stall. each column gives a coverage
// result; when a span closes (gap of MIN_GAP undeposited empty columns or row
// end) a span result follows it, and last marks the final result of a column.
// configuration: cfg_write with cfg_index 0 sets fill_mode, 1 sets x_origin;
// write only while no column is in flight.
// a taken column waits in the input register until the result queue has room,
// is then written into the queue and its first result is shown from there.
// throughput: one column per cycle while the result queue has room; a column
// that closes a span gives two results, which leave one at a time through the
// single result port behind the four-entry result queue.
// reset: rst clears the row state, registers and the result queue.
// when the receiver stalls the queue fills and cell_stall rises once the queue
// lacks room for two results; nothing is dropped.
module signed_area_row_coverage_scan #(
  parameter int MAX_ROW_WIDTH = sarcs_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MIN_GAP       = sarcs_pkg::MIN_GAP_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [sarcs_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [sarcs_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    cell_valid,
  output logic                                    cell_stall,
  input  logic signed [sarcs_pkg::DELTA_W-1:0]     cell_delta,
  input  logic                                    deposited,
  input  logic                                    last_in_row,
  input  logic        [sarcs_pkg::ROW_W-1:0]       row_y,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output logic                                    coverage_valid,
  output logic [sarcs_pkg::COV_W-1:0]              coverage_byte,
  output logic                                    span_valid,
  output logic [sarcs_pkg::SPANX_W-1:0]            span_x,
  output logic [sarcs_pkg::ROW_W-1:0]              span_y,
  output logic [sarcs_pkg::SLEN_W-1:0]             span_length,
  output logic                                    last
);

  logic                           fill_mode;
  logic [sarcs_pkg::XORG_W-1:0]   x_origin;
  logic                           room;
  sarcs_pkg::push_t               push;
  sarcs_pkg::result_t             result;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode <= 1'b0;
      x_origin  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sarcs_pkg::CFG_FILL_MODE: fill_mode <= cfg_data[0];
        sarcs_pkg::CFG_X_ORIGIN:  x_origin  <= cfg_data[sarcs_pkg::XORG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sarcs_scan #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .MIN_GAP       (MIN_GAP)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .cell_valid  (cell_valid),
    .cell_stall  (cell_stall),
    .cell_delta  (cell_delta),
    .deposited   (deposited),
    .last_in_row (last_in_row),
    .row_y       (row_y),
    .fill_mode   (fill_mode),
    .x_origin    (x_origin),
    .room        (room),
    .push        (push)
  );

  sarcs_result_fifo u_result_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign coverage_valid = result.coverage_valid;
  assign coverage_byte  = result.coverage_byte;
  assign span_valid     = result.span_valid;
  assign span_x         = result.span_x;
  assign span_y         = result.span_y;
  assign span_length    = result.span_length;
  assign last           = result.last;

endmodule

>>> rtl/sarcs_scan.sv
// input register, row state and per-column coverage and span logic
module sarcs_scan #(
  parameter int MAX_ROW_WIDTH = sarcs_pkg::MAX_ROW_WIDTH_DEF,
  parameter int MIN_GAP       = sarcs_pkg::MIN_GAP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  logic signed [sarcs_pkg::DELTA_W-1:0] cell_delta,
  input  logic                                deposited,
  input  logic                                last_in_row,
  input  logic        [sarcs_pkg::ROW_W-1:0]   row_y,
  input  logic                                fill_mode,
  input  logic        [sarcs_pkg::XORG_W-1:0]  x_origin,
  input  logic                                room,
  output sarcs_pkg::push_t                    push
);

  localparam int COL_W = $clog2(MAX_ROW_WIDTH);
  localparam int EXT_W = sarcs_pkg::WSUM_W - sarcs_pkg::DELTA_W;

  logic                             item_valid;
  logic [sarcs_pkg::DELTA_W-1:0]    item_delta;
  logic                             item_dep;
  logic                             item_end;
  logic [sarcs_pkg::ROW_W-1:0]      item_row;

  logic [sarcs_pkg::WSUM_W-1:0]     wsum, wsum_next, wsum_sum;
  logic [COL_W-1:0]                 col, col_next;
  logic                             span_open, span_open_next;
  logic [COL_W-1:0]                 span_first, span_first_next;
  logic [COL_W-1:0]                 span_last, span_last_next;
  logic [sarcs_pkg::GAP_W-1:0]      run, run_next, run_inc;
  logic [sarcs_pkg::COV_W-1:0]      cov;
  logic                             closed;
  logic                             row_stop;
  logic                             advance;
  logic                             accept;

  assign advance    = item_valid && room;
  assign cell_stall = item_valid && !room;
  assign accept     = cell_valid && !cell_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_delta <= cell_delta;
      item_dep   <= deposited;
      item_end   <= last_in_row;
      item_row   <= row_y;
    end
  end

  always_comb begin
    wsum_sum = item_dep ? (wsum + {{EXT_W{item_delta[sarcs_pkg::DELTA_W-1]}}, item_delta})
                        : wsum;
    cov      = sarcs_pkg::cover_byte(wsum_sum, fill_mode);
    run_inc  = run + 1'b1;
    wsum_next       = wsum_sum;
    col_next        = col;
    span_open_next  = span_open;
    span_first_next = span_first;
    span_last_next  = span_last;
    run_next        = run;
    closed          = 1'b0;

    if (cov != '0) begin
      if (!span_open) begin
        span_open_next  = 1'b1;
        span_first_next = col;
      end
      span_last_next = col;
      run_next       = '0;
    end else if (item_dep) begin
      run_next = '0;
    end else if (span_open) begin
      // undeposited empty column widens the gap
      if (run_inc >= sarcs_pkg::GAP_W'(MIN_GAP)) begin
        closed         = 1'b1;
        span_open_next = 1'b0;
        run_next       = '0;
      end else begin
        run_next = run_inc;
      end
    end

    row_stop = item_end || (col == COL_W'(MAX_ROW_WIDTH - 1));
    if (row_stop) begin
      if (span_open_next) begin
        closed = 1'b1;
      end
      span_open_next = 1'b0;
      run_next       = '0;
      wsum_next      = '0;
      col_next       = '0;
    end else begin
      col_next = col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum       <= '0;
      col        <= '0;
      span_open  <= 1'b0;
      span_first <= '0;
      span_last  <= '0;
      run        <= '0;
    end else if (advance) begin
      wsum       <= wsum_next;
      col        <= col_next;
      span_open  <= span_open_next;
      span_first <= span_first_next;
      span_last  <= span_last_next;
      run        <= run_next;
    end
  end

  always_comb begin
    push.valid                 = advance;
    push.two                   = closed;
    push.first.coverage_valid  = 1'b1;
    push.first.coverage_byte   = cov;
    push.first.span_valid      = 1'b0;
    push.first.span_x          = '0;
    push.first.span_y          = '0;
    push.first.span_length     = '0;
    push.first.last            = !closed;
    push.second.coverage_valid = 1'b0;
    push.second.coverage_byte  = '0;
    push.second.span_valid     = 1'b1;
    push.second.span_x         = sarcs_pkg::SPANX_W'(x_origin)
                               + sarcs_pkg::SPANX_W'(span_first_next);
    push.second.span_y         = item_row;
    push.second.span_length    = sarcs_pkg::SLEN_W'(span_last_next)
                               - sarcs_pkg::SLEN_W'(span_first_next) + 1'b1;
    push.second.last           = 1'b1;
  end

endmodule

>>> rtl/sarcs_result_fifo.sv
// small result queue taking up to two results a cycle and giving one
module sarcs_result_fifo (
  input  logic                clk,
  input  logic                rst,
  input  sarcs_pkg::push_t    push,
  output logic                room,
  output logic                result_valid,
  input  logic                result_stall,
  output sarcs_pkg::result_t  result
);

  sarcs_pkg::result_t                   mem [sarcs_pkg::FIFO_DEPTH];
  logic [sarcs_pkg::FIFO_PTR_W-1:0]     head;
  logic [sarcs_pkg::FIFO_PTR_W-1:0]     tail;
  logic [sarcs_pkg::FIFO_CNT_W-1:0]     count;
  logic [sarcs_pkg::FIFO_CNT_W-1:0]     push_n;
  logic                                 pop;

  assign result_valid = (count != '0);
  assign result       = mem[head];
  assign pop          = result_valid && !result_stall;
  // room for a full pair regardless of this cycle's pop
  assign room         = (count <= sarcs_pkg::FIFO_CNT_W'(sarcs_pkg::FIFO_DEPTH - 2));
  assign push_n       = !push.valid ? '0 : (push.two ? sarcs_pkg::FIFO_CNT_W'(2)
                                                     : sarcs_pkg::FIFO_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + sarcs_pkg::FIFO_PTR_W'(pop);
      tail  <= tail + sarcs_pkg::FIFO_PTR_W'(push_n);
      count <= count + push_n - sarcs_pkg::FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[tail] <= push.first;
      if (push.two) begin
        mem[sarcs_pkg::FIFO_PTR_W'(tail + 1'b1)] <= push.second;
      end
    end
  end

endmodule

>>> rtl/sarcs_checker.sv
// port-level checks of the row coverage scan, bound to the top level
`include "signed_area_row_coverage_scan_defines.svh"

module sarcs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              result_valid,
  input logic                              result_stall,
  input logic                              coverage_valid,
  input logic [sarcs_pkg::COV_W-1:0]        coverage_byte,
  input logic                              span_valid,
  input logic [sarcs_pkg::SPANX_W-1:0]      span_x,
  input logic [sarcs_pkg::ROW_W-1:0]        span_y,
  input logic [sarcs_pkg::SLEN_W-1:0]       span_length,
  input logic                              last
);

  logic                                    held;
  logic [$bits(sarcs_pkg::result_t)-1:0]   shown;

  assign held  = result_valid && result_stall;
  assign shown = {coverage_valid, coverage_byte, span_valid, span_x, span_y, span_length, last};

  `SARCS_ASSERT(a_stall_hold, held |=> result_valid && $stable(shown), "stalled result changed")
  `SARCS_ASSERT(a_one_kind, result_valid |-> coverage_valid != span_valid,
                "result must carry either coverage or a span")
  `SARCS_ASSERT(a_span_last, result_valid && span_valid |-> last, "span result must end the column")
  `SARCS_ASSERT(a_span_len, result_valid && span_valid |-> span_length != '0,
                "closed span has zero length")
  `SARCS_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result shown right after reset")

endmodule

bind signed_area_row_coverage_scan sarcs_checker u_sarcs_checker (.*);
